@@ src/ps2hb_pkg.sv @@
package ps2hb_pkg;

    localparam int unsigned IdleW = 10;
    localparam int unsigned BitIdxW = 4;
    localparam int unsigned StepW = 4;

    localparam logic [IdleW-1:0] IDLE_MAX = '1;
    localparam logic [IdleW-1:0] TIMEOUT_RESET = IdleW'(250);

    // receive bit index of the last frame bit (stop); the next edge wraps
    localparam logic [BitIdxW-1:0] RX_LAST_IDX = BitIdxW'(10);
    localparam logic [BitIdxW-1:0] RX_FIRST_DATA = BitIdxW'(1);
    localparam logic [BitIdxW-1:0] RX_LAST_DATA = BitIdxW'(8);

    // command codes
    localparam logic [1:0] CMD_TICK = 2'd0;
    localparam logic [1:0] CMD_EDGE = 2'd1;
    localparam logic [1:0] CMD_SEND = 2'd2;

    // transmit sequence steps
    localparam logic [StepW-1:0] TX_IDLE = StepW'(0);
    localparam logic [StepW-1:0] TX_START = StepW'(1);
    localparam logic [StepW-1:0] TX_LAST_DATA = StepW'(8);
    localparam logic [StepW-1:0] TX_PARITY = StepW'(9);
    localparam logic [StepW-1:0] TX_RELEASE = StepW'(10);

    typedef struct packed {
        logic tick;
        logic rx_edge;
        logic line;
    } t_rx_ctl;

    typedef struct packed {
        logic       valid;
        logic [7:0] code;
    } t_rx_res;

endpackage

@@ src/ps2hb_if.sv @@
interface ps2hb_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic       data_line;
    logic [7:0] send_byte;

    modport source (output valid, output command, output data_line, output send_byte,
                    input ready);
    modport sink (input valid, input command, input data_line, input send_byte,
                  output ready);
endinterface

interface ps2hb_out_if;
    logic       valid;
    logic       ready;
    logic       data_drive_enable;
    logic       data_drive_level;
    logic       rx_valid;
    logic [7:0] rx_code;
    logic       tx_busy;
    logic       tx_done;
    logic       ack_level;

    modport source (output valid, output data_drive_enable, output data_drive_level,
                    output rx_valid, output rx_code, output tx_busy, output tx_done,
                    output ack_level, input ready);
    modport sink (input valid, input data_drive_enable, input data_drive_level,
                  input rx_valid, input rx_code, input tx_busy, input tx_done,
                  input ack_level, output ready);
endinterface

interface ps2hb_cfg_if;
    logic       valid;
    logic       ready;
    logic [9:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ src/ps2hb_rx.sv @@
module ps2hb_rx (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ps2hb_pkg::t_rx_ctl          i_ctl,
    input  logic [ps2hb_pkg::IdleW-1:0] i_timeout,
    output ps2hb_pkg::t_rx_res          o_res
);
    import ps2hb_pkg::*;

    logic [BitIdxW-1:0] r_idx, n_idx;
    logic [7:0]         r_shift, n_shift;
    logic [IdleW-1:0]   r_idle, n_idle;

    logic               restart;
    logic [BitIdxW-1:0] idx0;
    logic [7:0]         sh0;
    logic [7:0]         sh1;

    always_comb begin
        restart = r_idle > i_timeout;
        idx0    = restart ? '0 : r_idx;
        sh0     = restart ? '0 : r_shift;
        sh1     = (idx0 >= RX_FIRST_DATA && idx0 <= RX_LAST_DATA) ?
                  {i_ctl.line, sh0[7:1]} : sh0;

        n_idx   = r_idx;
        n_shift = r_shift;
        n_idle  = r_idle;
        o_res   = '0;

        if (i_ctl.tick) begin
            if (r_idle != IDLE_MAX) n_idle = r_idle + IdleW'(1);
        end else if (i_ctl.rx_edge) begin
            n_idle = '0;
            if (idx0 >= RX_LAST_IDX) begin
                // stop bit: report the byte and restart framing
                o_res.valid = 1'b1;
                o_res.code  = sh1;
                n_shift     = '0;
                n_idx       = '0;
            end else begin
                n_shift = sh1;
                n_idx   = idx0 + BitIdxW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_shift <= '0;
            r_idle  <= IDLE_MAX;
        end else begin
            r_idx   <= n_idx;
            r_shift <= n_shift;
            r_idle  <= n_idle;
        end
    end

endmodule

@@ src/ps2hb_engine.sv @@
// PS/2 host bit engine.
// A result is registered and presented in the cycle after its input transfer.
// Throughput: one item per cycle; the result register lets a new item in
// while the previous result waits, as long as the sink takes it that cycle.
// Reset (synchronous, active low): framing and transmit idle, data released,
// idle count saturated, frame timeout 250 ticks, no result pending.
module ps2_host_bit_engine (
    input  logic             i_clk,
    input  logic             i_rst_n,
    ps2hb_in_if.sink         i_item,
    ps2hb_cfg_if.sink        i_cfg,
    ps2hb_out_if.source      o_result
);
    import ps2hb_pkg::*;

    logic [IdleW-1:0] r_timeout;

    logic [StepW-1:0] r_step, n_step;
    logic [7:0]       r_tx_shift, n_tx_shift;
    logic             r_parity, n_parity;
    logic             r_drv_en, n_drv_en;
    logic             r_drv_lvl, n_drv_lvl;

    logic             r_res_valid;
    logic             r_rx_valid;
    logic [7:0]       r_rx_code;
    logic             r_tx_done, n_tx_done;
    logic             r_ack, n_ack;

    logic             accept;
    t_rx_ctl          rx_ctl;
    t_rx_res          rx_res;

    assign i_cfg.ready  = 1'b1;
    assign i_item.ready = !r_res_valid || o_result.ready;
    assign accept       = i_item.valid && i_item.ready;

    assign rx_ctl.tick    = accept && (i_item.command == CMD_TICK);
    assign rx_ctl.rx_edge = accept && (i_item.command == CMD_EDGE) && (r_step == TX_IDLE);
    assign rx_ctl.line    = i_item.data_line;

    ps2hb_rx u_rx (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (rx_ctl),
        .i_timeout (r_timeout),
        .o_res     (rx_res)
    );

    always_comb begin
        n_step     = r_step;
        n_tx_shift = r_tx_shift;
        n_parity   = r_parity;
        n_drv_en   = r_drv_en;
        n_drv_lvl  = r_drv_lvl;
        n_tx_done  = 1'b0;
        n_ack      = 1'b0;

        if (i_item.command == CMD_EDGE && r_step != TX_IDLE) begin
            priority if (r_step <= TX_LAST_DATA) begin
                n_drv_lvl  = r_tx_shift[0];
                n_tx_shift = {1'b0, r_tx_shift[7:1]};
                n_step     = r_step + StepW'(1);
            end else if (r_step == TX_PARITY) begin
                n_drv_lvl = r_parity;
                n_step    = r_step + StepW'(1);
            end else if (r_step == TX_RELEASE) begin
                n_drv_en  = 1'b0;
                n_drv_lvl = 1'b0;
                n_step    = r_step + StepW'(1);
            end else begin
                // sample the device acknowledge and end the send
                n_ack     = i_item.data_line;
                n_tx_done = 1'b1;
                n_step    = TX_IDLE;
            end
        end else if (i_item.command == CMD_SEND && r_step == TX_IDLE) begin
            n_step     = TX_START;
            n_tx_shift = i_item.send_byte;
            n_parity   = ~^i_item.send_byte;
            n_drv_en   = 1'b1;
            n_drv_lvl  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout   <= TIMEOUT_RESET;
            r_step      <= TX_IDLE;
            r_tx_shift  <= '0;
            r_parity    <= 1'b0;
            r_drv_en    <= 1'b0;
            r_drv_lvl   <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) r_timeout <= i_cfg.data;
            if (accept) begin
                r_step      <= n_step;
                r_tx_shift  <= n_tx_shift;
                r_parity    <= n_parity;
                r_drv_en    <= n_drv_en;
                r_drv_lvl   <= n_drv_lvl;
                r_res_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    // result payload: no reset needed
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rx_valid <= rx_res.valid;
            r_rx_code  <= rx_res.code;
            r_tx_done  <= n_tx_done;
            r_ack      <= n_ack;
        end
    end

    assign o_result.valid             = r_res_valid;
    assign o_result.data_drive_enable = r_drv_en;
    assign o_result.data_drive_level  = r_drv_lvl;
    assign o_result.rx_valid          = r_rx_valid;
    assign o_result.rx_code           = r_rx_code;
    assign o_result.tx_busy           = (r_step != TX_IDLE);
    assign o_result.tx_done           = r_tx_done;
    assign o_result.ack_level         = r_ack;

endmodule

@@ src/ps2hb_checker.sv @@
module ps2hb_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_drv_en,
    input logic       i_rx_valid,
    input logic [7:0] i_rx_code,
    input logic       i_tx_busy,
    input logic       i_tx_done,
    input logic       i_ack
);

    // a pending result stays until transferred
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // every input transfer yields a result in the next cycle
    a_in_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> i_out_valid)
        else $error("no result after input transfer");

    // the end of a send releases the line and clears busy
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_tx_done |-> !i_tx_busy && !i_drv_en)
        else $error("send done while still busy or driving");

    // host drives the line only while a send is in progress
    a_drive_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_drv_en |-> i_tx_busy)
        else $error("data driven while not sending");

    // received code and ack level are zero unless flagged
    a_quiet_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_rx_valid || i_rx_code == 8'd0) && (i_tx_done || !i_ack))
        else $error("unflagged code or ack is nonzero");

endmodule

bind ps2_host_bit_engine ps2hb_checker u_ps2hb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_item.valid),
    .i_in_ready  (i_item.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_drv_en    (o_result.data_drive_enable),
    .i_rx_valid  (o_result.rx_valid),
    .i_rx_code   (o_result.rx_code),
    .i_tx_busy   (o_result.tx_busy),
    .i_tx_done   (o_result.tx_done),
    .i_ack       (o_result.ack_level)
);
